### design/mdt_pkg.sv
// shared types, character codes and helpers for the dependency-file tokenizer
// no dependencies; imported by every module of the block
`default_nettype none

package mdt_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int OUT_BITS          = 32;
    localparam int QUEUE_DEPTH       = 4;
    localparam int MAX_EVENTS        = 3;

    // parse modes
    localparam logic [2:0] M_TARGET_SKIP = 3'd0;
    localparam logic [2:0] M_COMMENT     = 3'd1;
    localparam logic [2:0] M_TARGET_WORD = 3'd2;
    localparam logic [2:0] M_COLON       = 3'd3;
    localparam logic [2:0] M_PREREQ_SKIP = 3'd4;
    localparam logic [2:0] M_PREREQ_WORD = 3'd5;
    localparam logic [2:0] M_SKIP_LINE   = 3'd6;

    // event kinds
    localparam logic [1:0] EV_START = 2'd0;
    localparam logic [1:0] EV_DEP   = 2'd1;
    localparam logic [1:0] EV_END   = 2'd2;
    localparam logic [1:0] EV_ERR   = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_TARGET = 2'd0;
    localparam logic [1:0] ERR_COLON  = 2'd1;
    localparam logic [1:0] ERR_PREREQ = 2'd2;

    // characters
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_NUL     = 8'h00;

    typedef struct packed {
        logic [1:0]          kind;
        logic [OUT_BITS-1:0] offset;
        logic [OUT_BITS-1:0] length;
        logic [1:0]          code;
    } t_event;

    // all events caused by one byte, slot 0 first
    typedef struct packed {
        logic [1:0]                  cnt;
        t_event [MAX_EVENTS-1:0]     ev;
    } t_bundle;

    function automatic logic is_word(input logic [7:0] c);
        logic r;
        r = !(c == CH_NUL || c == CH_TAB || c == CH_NL || c == CH_SPACE ||
              c == CH_DOLLAR || c == CH_COLON || c == CH_SEMI || c == CH_EQUAL ||
              c == CH_PIPE || c == CH_PERCENT);
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    // append one event, dropping it once all slots are taken
    function automatic t_bundle push(input t_bundle b, input logic [1:0] kind,
                                     input logic [OUT_BITS-1:0] offset,
                                     input logic [OUT_BITS-1:0] length,
                                     input logic [1:0] code);
        t_bundle r;
        r = b;
        if (r.cnt != 2'(MAX_EVENTS)) begin
            r.ev[r.cnt].kind   = kind;
            r.ev[r.cnt].offset = offset;
            r.ev[r.cnt].length = length;
            r.ev[r.cnt].code   = code;
            r.cnt              = r.cnt + 2'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/mdt_front.sv
// front end: takes one byte per cycle, runs the parse state and builds the event bundle
// depends on mdt_pkg; writes bundles into mdt_queue, taking no byte while it is full
`default_nettype none

module mdt_front
    import mdt_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire logic [7:0] i_data,
    input  wire logic    i_final,
    input  wire logic    i_q_full,
    output logic         o_q_write,
    output t_bundle      o_q_bundle
);

    localparam int PB  = POSITION_BITS;
    localparam int EXT = (PB > OUT_BITS) ? PB : OUT_BITS;
    localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

    logic [2:0]    r_mode, n_mode;
    logic [PB-1:0] r_pos, n_pos;
    logic [PB-1:0] r_begin, n_begin;
    logic          r_esc, n_esc;
    logic [PB-1:0] r_esc_at, n_esc_at;

    logic          acc;
    logic [PB-1:0] p, e;
    logic          do_colon, do_prereq;
    t_bundle       b;

    function automatic logic [OUT_BITS-1:0] to_out(input logic [PB-1:0] v);
        logic [EXT-1:0] t;
        t = EXT'(v);
        return t[OUT_BITS-1:0];
    endfunction

    assign o_ready = !i_q_full;
    assign acc     = i_valid && o_ready;
    assign p       = r_pos;
    assign e       = (r_pos == POS_MAX) ? r_pos : r_pos + PB'(1);

    always_comb begin
        b         = '0;
        n_mode    = r_mode;
        n_esc     = 1'b0;
        n_esc_at  = r_esc_at;
        n_begin   = r_begin;
        do_colon  = 1'b0;
        do_prereq = 1'b0;

        unique case (r_mode)
            M_TARGET_SKIP: begin
                if (r_esc) begin
                    if (i_data == CH_NL) begin
                        b = push(b, EV_ERR, to_out(r_esc_at), '0, ERR_TARGET);
                    end else begin
                        n_begin = r_esc_at;
                        n_mode  = M_TARGET_WORD;
                    end
                end else if (i_data == CH_HASH) begin
                    n_mode = M_COMMENT;
                end else if (is_blank(i_data) || i_data == CH_NL) begin
                    n_mode = r_mode;
                end else if (i_data == CH_BSLASH) begin
                    n_esc    = 1'b1;
                    n_esc_at = p;
                end else if (is_word(i_data)) begin
                    n_begin = p;
                    n_mode  = M_TARGET_WORD;
                end else begin
                    b      = push(b, EV_ERR, to_out(p), '0, ERR_TARGET);
                    n_mode = M_SKIP_LINE;
                end
            end
            M_COMMENT: begin
                if (i_data == CH_NL) n_mode = M_TARGET_SKIP;
            end
            M_TARGET_WORD: begin
                if (r_esc) begin
                    if (i_data == CH_NL) begin
                        b = push(b, EV_START, to_out(r_begin),
                                 to_out(PB'(r_esc_at - r_begin)), ERR_NONE);
                        n_mode = M_COLON;
                    end
                end else if (i_data == CH_BSLASH) begin
                    n_esc    = 1'b1;
                    n_esc_at = p;
                end else if (!is_word(i_data)) begin
                    b = push(b, EV_START, to_out(r_begin),
                             to_out(PB'(p - r_begin)), ERR_NONE);
                    n_mode   = M_COLON;
                    do_colon = 1'b1;
                end
            end
            M_COLON: begin
                if (!r_esc) begin
                    do_colon = 1'b1;
                end else if (i_data != CH_NL) begin
                    b      = push(b, EV_ERR, to_out(r_esc_at), '0, ERR_COLON);
                    b      = push(b, EV_END, '0, '0, ERR_NONE);
                    n_mode = M_SKIP_LINE;
                end
            end
            M_PREREQ_SKIP: begin
                if (!r_esc) begin
                    do_prereq = 1'b1;
                end else if (i_data != CH_NL) begin
                    n_begin = r_esc_at;
                    n_mode  = M_PREREQ_WORD;
                end
            end
            M_PREREQ_WORD: begin
                if (r_esc) begin
                    if (i_data == CH_NL) begin
                        b = push(b, EV_DEP, to_out(r_begin),
                                 to_out(PB'(r_esc_at - r_begin)), ERR_NONE);
                        n_mode = M_PREREQ_SKIP;
                    end
                end else if (i_data == CH_BSLASH) begin
                    n_esc    = 1'b1;
                    n_esc_at = p;
                end else if (!is_word(i_data)) begin
                    b = push(b, EV_DEP, to_out(r_begin),
                             to_out(PB'(p - r_begin)), ERR_NONE);
                    n_mode    = M_PREREQ_SKIP;
                    do_prereq = 1'b1;
                end
            end
            default: begin
                if (i_data == CH_NL) n_mode = M_TARGET_SKIP;
            end
        endcase

        // byte handling shared by the word states, the colon state and the prerequisite skip state
        if (do_colon) begin
            if (is_blank(i_data)) begin
                n_mode = M_COLON;
            end else if (i_data == CH_BSLASH) begin
                n_esc    = 1'b1;
                n_esc_at = p;
            end else if (i_data == CH_COLON) begin
                n_mode = M_PREREQ_SKIP;
            end else begin
                b      = push(b, EV_ERR, to_out(p), '0, ERR_COLON);
                b      = push(b, EV_END, '0, '0, ERR_NONE);
                n_mode = (i_data == CH_NL) ? M_TARGET_SKIP : M_SKIP_LINE;
            end
        end
        if (do_prereq) begin
            if (is_blank(i_data)) begin
                n_mode = M_PREREQ_SKIP;
            end else if (i_data == CH_BSLASH) begin
                n_esc    = 1'b1;
                n_esc_at = p;
            end else if (i_data == CH_NL) begin
                b      = push(b, EV_END, '0, '0, ERR_NONE);
                n_mode = M_TARGET_SKIP;
            end else if (is_word(i_data)) begin
                n_begin = p;
                n_mode  = M_PREREQ_WORD;
            end else begin
                b      = push(b, EV_ERR, to_out(p), '0, ERR_PREREQ);
                b      = push(b, EV_END, '0, '0, ERR_NONE);
                n_mode = M_SKIP_LINE;
            end
        end

        // end of file closes whatever is still open
        if (i_final) begin
            unique case (n_mode)
                M_TARGET_SKIP: begin
                    if (n_esc) begin
                        b = push(b, EV_START, to_out(n_esc_at),
                                 to_out(PB'(e - n_esc_at)), ERR_NONE);
                        b = push(b, EV_ERR, to_out(e), '0, ERR_COLON);
                        b = push(b, EV_END, '0, '0, ERR_NONE);
                    end
                end
                M_TARGET_WORD: begin
                    b = push(b, EV_START, to_out(n_begin),
                             to_out(PB'(e - n_begin)), ERR_NONE);
                    b = push(b, EV_ERR, to_out(e), '0, ERR_COLON);
                    b = push(b, EV_END, '0, '0, ERR_NONE);
                end
                M_COLON: begin
                    b = push(b, EV_ERR, to_out(n_esc ? n_esc_at : e), '0, ERR_COLON);
                    b = push(b, EV_END, '0, '0, ERR_NONE);
                end
                M_PREREQ_SKIP: begin
                    if (n_esc) begin
                        b = push(b, EV_DEP, to_out(n_esc_at),
                                 to_out(PB'(e - n_esc_at)), ERR_NONE);
                    end
                    b = push(b, EV_END, '0, '0, ERR_NONE);
                end
                M_PREREQ_WORD: begin
                    b = push(b, EV_DEP, to_out(n_begin),
                             to_out(PB'(e - n_begin)), ERR_NONE);
                    b = push(b, EV_END, '0, '0, ERR_NONE);
                end
                default: begin
                    b = b;
                end
            endcase
            n_mode = M_TARGET_SKIP;
            n_esc  = 1'b0;
            n_pos  = '0;
        end else begin
            n_pos = e;
        end
    end

    assign o_q_write  = acc && (b.cnt != 2'd0);
    assign o_q_bundle = b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_TARGET_SKIP;
            r_pos  <= '0;
            r_esc  <= 1'b0;
        end else if (acc) begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_esc  <= n_esc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_begin  <= n_begin;
            r_esc_at <= n_esc_at;
        end
    end

    a_final_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_final) |=> (r_mode == M_TARGET_SKIP && r_pos == '0 && !r_esc))
        else $error("front did not restart after the final byte");

    a_no_empty_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_write |-> (o_q_bundle.cnt != 2'd0 && !i_q_full))
        else $error("empty bundle or write into a full queue");

    a_pos_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !i_final && $past(i_rst_n)) |=> (r_pos != '0))
        else $error("byte position wrapped");

endmodule

`default_nettype wire

### design/mdt_queue.sv
// short bundle queue between the front and back ends
// depends on mdt_pkg for the bundle type and depth
`default_nettype none

module mdt_queue
    import mdt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_write,
    input  wire t_bundle i_bundle,
    output logic         o_full,
    input  wire logic    i_pop,
    output logic         o_valid,
    output t_bundle      o_head
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_bundle         r_mem [QUEUE_DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_write) r_wp <= r_wp + AW'(1);
            if (i_pop)   r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(i_write) - (AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_write) r_mem[r_wp] <= i_bundle;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_write && o_full) && !(i_pop && !o_valid))
        else $error("queue overflow or underflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with empty count");

endmodule

`default_nettype wire

### design/mdt_back.sv
// back end: hands out the events of each queued bundle one per cycle while the output is not stalled
// depends on mdt_pkg; reads from mdt_queue, drives the result register
`default_nettype none

module mdt_back
    import mdt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_q_valid,
    input  wire t_bundle i_q_head,
    output logic         o_q_pop,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_event       o_event,
    output logic         o_last
);

    logic [1:0] r_idx;
    logic       r_valid;
    t_event     r_event;
    logic       r_last;
    logic       load;
    logic       at_last;

    assign load    = i_q_valid && (!r_valid || i_ready);
    assign at_last = (r_idx == 2'(i_q_head.cnt - 2'd1));
    assign o_q_pop = load && at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= at_last ? 2'd0 : r_idx + 2'd1;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_event <= i_q_head.ev[r_idx];
            r_last  <= at_last;
        end
    end

    assign o_valid = r_valid;
    assign o_event = r_event;
    assign o_last  = r_last;

    a_idx_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (r_idx < i_q_head.cnt))
        else $error("event index beyond bundle count");

    a_pop_resets_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_idx == 2'd0 && r_valid && r_last))
        else $error("bundle popped without closing its last event");

    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_valid |-> (r_idx == 2'd0))
        else $error("event index left open with empty queue");

endmodule

`default_nettype wire

### design/make_deps_tokenizer.sv
// top level of the dependency-file tokenizer: front end, bundle queue, back end
// depends on mdt_pkg, mdt_front, mdt_queue, mdt_back
//
// channel   dir  tdata                                   tuser          tlast
// s_axis    in   [7:0] data_byte                         -              final_byte
// m_axis    out  [31:0] word_offset [63:32] word_length  [1:0] kind     last_event
//                [65:64] error_code, rest zero
//
// a byte is taken every cycle while the bundle queue has room
// each byte makes zero to three events, handed out one per cycle by the back end while
// the output is not stalled, so the sustained rate is one byte per cycle while bytes
// average at most one event
// reset is synchronous and clears parse state, queue and output valid; no clearing pass
// a stalled result waits in the output register while bytes keep filling the queue
`default_nettype none

module make_deps_tokenizer
    import mdt_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [71:0]      o_m_axis_tdata,   // [31:0] offset, [63:32] length, [65:64] code
    output logic [1:0]       o_m_axis_tuser,   // [1:0] event_kind
    output logic             o_m_axis_tlast
);

    logic    q_write, q_full, q_pop, q_valid;
    t_bundle q_in, q_head;
    t_event  ev;

    mdt_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_data     (i_s_axis_tdata),
        .i_final    (i_s_axis_tlast),
        .i_q_full   (q_full),
        .o_q_write  (q_write),
        .o_q_bundle (q_in)
    );

    mdt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_write  (q_write),
        .i_bundle (q_in),
        .o_full   (q_full),
        .i_pop    (q_pop),
        .o_valid  (q_valid),
        .o_head   (q_head)
    );

    mdt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_event   (ev),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {6'd0, ev.code, ev.length, ev.offset};
    assign o_m_axis_tuser = ev.kind;

endmodule

`default_nettype wire
